// File: hw/rtl/vdi_pkg.sv
// Package: constants and helpers shared by the vertex dedup indexer.
package vdi_pkg;
  localparam int VertexCapDef = 4096;
  localparam int HashSlotsDef = 8192;
  localparam int IndexW = 12;

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] b);
    return (b[30:0] == 31'd0) ? 32'd0 : b;
  endfunction

  function automatic logic [31:0] xshift(input logic [31:0] h, input int s);
    return h ^ (h >> s);
  endfunction
endpackage

// File: hw/rtl/vdi_hash.sv
// Multi-cycle position hash: one multiply per cycle.
module vdi_hash import vdi_pkg::*; #(
  parameter int HashSlots = HashSlotsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [95:0]                  pos,
  output logic                         done,
  output logic [$clog2(HashSlots)-1:0] slot
);
  localparam int SW = $clog2(HashSlots);
  localparam logic [31:0] Gold = 32'h9E3779B9;

  logic [31:0] h_r, h_nxt;
  logic [1:0]  comp_r, comp_nxt;
  logic        ph_r, ph_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] c;

  always_comb begin
    case (comp_r)
      2'd0: c = canon(pos[31:0]);
      2'd1: c = canon(pos[63:32]);
      default: c = canon(pos[95:64]);
    endcase
  end

  always_comb begin
    h_nxt = h_r; comp_nxt = comp_r; ph_nxt = ph_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      h_nxt = Gold; comp_nxt = 2'd0; ph_nxt = 1'b0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!ph_r) begin
        h_nxt = xshift(h_r ^ c, 16) * 32'h7FEB352D;
        ph_nxt = 1'b1;
      end else begin
        h_nxt = xshift(xshift(h_r, 15) * 32'h846CA68B, 16) + Gold;
        ph_nxt = 1'b0;
        if (comp_r == 2'd2) begin
          busy_nxt = 1'b0; done_nxt = 1'b1;
        end else begin
          comp_nxt = comp_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; ph_r <= 1'b0; comp_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; ph_r <= ph_nxt; comp_r <= comp_nxt;
    end
    h_r <= h_nxt;
  end

  assign done = done_r;
  assign slot = h_r[SW-1:0];
endmodule

// File: hw/rtl/vertex_dedup_indexer.sv
// Top level: vertex position dedup with hashed slot table and position store.
// channel | dir | ports
// in      | in  | in_valid, in_stall, in_command, in_pos_x/y/z
// out     | out | out_valid, out_stall, out_vert_idx, out_is_new, out_overflow
// Lookup: a transfer starts the hash, then the home slot is read; an empty slot ends the
// lookup, and each occupied slot probed adds a slot read, a position read and a compare.
// A position with a NaN does not wait for the hash and skips the probe.
// Reset and each clear sweep all HASH_SLOTS entries of the slot memory; no input is taken meanwhile.
// Input stalls from transfer until the result reaches the output register;
// a result held there by out_stall does not block the next transfer.
module vertex_dedup_indexer import vdi_pkg::*; #(
  parameter int VERTEX_CAP = VertexCapDef,
  parameter int HASH_SLOTS = HashSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_vert_idx,
  output logic        out_is_new,
  output logic        out_overflow
);
  localparam int SW = $clog2(HASH_SLOTS);
  localparam int VW = $clog2(VERTEX_CAP);
  localparam int CW = VW + 1;
  localparam logic [CW-1:0] Cap = CW'(VERTEX_CAP);
  localparam logic [SW:0] NSlots = (SW+1)'(HASH_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_SLOT, S_ENTRY, S_CMP, S_EMIT
  } state_t;

  logic [CW-1:0] slot_mem [HASH_SLOTS];
  logic [95:0]   pos_mem  [VERTEX_CAP];

  state_t        state_r;
  logic [95:0]   pos_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] slot_r;
  logic [SW:0]   probes_r;
  logic [CW-1:0] entry_r, slot_rd;
  logic [95:0]   pos_rd;
  logic          hstart_r, hdone;
  logic [SW-1:0] hslot;
  logic          ov_r, ow_r;
  logic [11:0]   oidx_r;
  logic          onew_r, oovf_r;
  logic [11:0]   ridx;
  logic          rnew, rovf;
  logic          sw_en;
  logic [SW-1:0] sw_addr;
  logic [CW-1:0] sw_data;
  logic          pw_en;
  logic          eq, nan_in;

  vdi_hash #(.HashSlots(HASH_SLOTS)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(hstart_r), .pos(pos_r), .done(hdone), .slot(hslot)
  );

  assign nan_in = is_nan(pos_r[31:0]) || is_nan(pos_r[63:32]) || is_nan(pos_r[95:64]);
  assign eq = !is_nan(pos_rd[31:0]) && !is_nan(pos_rd[63:32]) && !is_nan(pos_rd[95:64])
      && canon(pos_rd[31:0]) == canon(pos_r[31:0])
      && canon(pos_rd[63:32]) == canon(pos_r[63:32])
      && canon(pos_rd[95:64]) == canon(pos_r[95:64]);

  assign in_stall = !(state_r == S_IDLE && !ow_r);

  always_ff @(posedge clk) begin
    if (sw_en) slot_mem[sw_addr] <= sw_data;
    slot_rd <= slot_mem[slot_r];
    if (pw_en) pos_mem[count_r[VW-1:0]] <= pos_r;
    pos_rd <= pos_mem[entry_r[VW-1:0] - VW'(1)];
  end

  always_comb begin
    sw_en = 1'b0; sw_addr = slot_r; sw_data = '0; pw_en = 1'b0;
    if (state_r == S_CLEAR) sw_en = 1'b1;
    if (state_r == S_ENTRY && slot_rd == '0 && count_r < Cap) begin
      sw_en = 1'b1; sw_data = count_r + CW'(1); pw_en = 1'b1;
    end
    if (state_r == S_IDLE && ow_r && nan_in && rnew) pw_en = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; slot_r <= '0; count_r <= '0; hstart_r <= 1'b0;
      ov_r <= 1'b0; ow_r <= 1'b0;
    end else begin
      hstart_r <= (state_r == S_IDLE) && !ow_r && in_valid && !in_command;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          slot_r <= slot_r + SW'(1);
          if (slot_r == SW'(HASH_SLOTS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (ow_r) begin
            if (!ov_r) begin
              ow_r <= 1'b0;
              ov_r <= 1'b1; oidx_r <= ridx; onew_r <= rnew; oovf_r <= rovf;
              if (rnew) count_r <= count_r + CW'(1);
            end
          end else if (in_valid) begin
            pos_r <= {in_pos_z, in_pos_y, in_pos_x};
            if (in_command) begin
              count_r <= '0; slot_r <= '0; state_r <= S_CLEAR;
              ow_r <= 1'b1; ridx <= '0; rnew <= 1'b0; rovf <= 1'b0;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (nan_in) begin
            ow_r <= 1'b1; state_r <= S_IDLE;
            ridx <= (count_r < Cap) ? 12'(count_r) : '0;
            rnew <= count_r < Cap; rovf <= !(count_r < Cap);
          end else if (hdone && !hstart_r) begin
            slot_r <= hslot; probes_r <= '0; state_r <= S_SLOT;
          end
        end
        S_SLOT: state_r <= S_ENTRY;
        S_ENTRY: begin
          entry_r <= slot_rd;
          if (slot_rd == '0) begin
            ow_r <= 1'b1; state_r <= S_IDLE;
            if (count_r < Cap) begin
              ridx <= 12'(count_r); rnew <= 1'b1; rovf <= 1'b0;
            end else begin
              ridx <= '0; rnew <= 1'b0; rovf <= 1'b1;
            end
          end else state_r <= S_CMP;
        end
        S_CMP: state_r <= S_EMIT;
        S_EMIT: begin
          if ((entry_r <= count_r) && eq) begin
            ow_r <= 1'b1; state_r <= S_IDLE;
            ridx <= 12'(entry_r - CW'(1)); rnew <= 1'b0; rovf <= 1'b0;
          end else if (probes_r == NSlots - (SW+1)'(1)) begin
            ow_r <= 1'b1; state_r <= S_IDLE;
            ridx <= '0; rnew <= 1'b0; rovf <= 1'b1;
          end else begin
            probes_r <= probes_r + (SW+1)'(1);
            slot_r <= slot_r + SW'(1);
            state_r <= S_SLOT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_vert_idx = oidx_r;
  assign out_is_new = onew_r;
  assign out_overflow = oovf_r;
endmodule

// File: sim/vdi_checker.sv
// Checker: predicts each vertex lookup result and compares it with the block's output.
`timescale 1ns / 100ps
module vdi_checker import vdi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_vert_idx,
  input  logic        out_is_new,
  input  logic        out_overflow,
  output int          fail_count,
  output int          pending,
  output int          n_new,
  output int          n_hit,
  output int          n_ovf,
  output int          n_clr
);
  localparam int Cap = VertexCapDef;
  localparam int Slots = HashSlotsDef;

  typedef struct packed {
    logic [IndexW-1:0] vidx;
    logic              fresh;
    logic              ovf;
  } lookup_res_t;

  logic [95:0] stored_pos [Cap];
  int          slot_ref [Slots];
  int          stored_cnt;
  lookup_res_t res_q [$];

  function automatic logic comp_nan(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 0);
  endfunction

  function automatic logic [31:0] comp_zero_fold(logic [31:0] b);
    return (b[30:0] == 0) ? 32'd0 : b;
  endfunction

  function automatic logic comp_match(logic [31:0] a, logic [31:0] b);
    if (comp_nan(a) || comp_nan(b)) return 1'b0;
    return comp_zero_fold(a) == comp_zero_fold(b);
  endfunction

  function automatic logic [31:0] scramble(logic [31:0] h);
    h = h ^ (h >> 16);
    h = h * 32'h7FEB352D;
    h = h ^ (h >> 15);
    h = h * 32'h846CA68B;
    h = h ^ (h >> 16);
    return h;
  endfunction

  function automatic int home_slot(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] h;
    h = 32'h9E3779B9;
    h = scramble(h ^ comp_zero_fold(x)) + 32'h9E3779B9;
    h = scramble(h ^ comp_zero_fold(y)) + 32'h9E3779B9;
    h = scramble(h ^ comp_zero_fold(z)) + 32'h9E3779B9;
    return int'(h % Slots);
  endfunction

  task automatic predict_lookup(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z);
    lookup_res_t r;
    int s;
    int idx;
    logic done;
    r = '0;
    done = 1'b0;
    if (cmd) begin
      foreach (slot_ref[i]) slot_ref[i] = 0;
      stored_cnt = 0;
      n_clr++;
    end else if (comp_nan(x) || comp_nan(y) || comp_nan(z)) begin
      if (stored_cnt >= Cap) begin
        r.ovf = 1'b1;
      end else begin
        stored_pos[stored_cnt] = {x, y, z};
        r.vidx = stored_cnt[IndexW-1:0];
        r.fresh = 1'b1;
        stored_cnt++;
      end
    end else begin
      s = home_slot(x, y, z);
      r.ovf = 1'b1;
      for (int n = 0; n < Slots && !done; n++) begin
        if (slot_ref[s] == 0) begin
          done = 1'b1;
          if (stored_cnt < Cap) begin
            stored_pos[stored_cnt] = {x, y, z};
            slot_ref[s] = stored_cnt + 1;
            r.vidx = stored_cnt[IndexW-1:0];
            r.fresh = 1'b1;
            r.ovf = 1'b0;
            stored_cnt++;
          end
        end else begin
          idx = slot_ref[s] - 1;
          if (idx < stored_cnt && comp_match(stored_pos[idx][95:64], x) &&
              comp_match(stored_pos[idx][63:32], y) && comp_match(stored_pos[idx][31:0], z)) begin
            done = 1'b1;
            r.vidx = idx[IndexW-1:0];
            r.ovf = 1'b0;
          end
        end
        s = (s + 1) % Slots;
      end
    end
    if (r.fresh) n_new++;
    else if (r.ovf) n_ovf++;
    else if (!cmd) n_hit++;
    res_q = {res_q, r};
  endtask

  task automatic report(input string fld, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, fld, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    n_new = 0;
    n_hit = 0;
    n_ovf = 0;
    n_clr = 0;
    stored_cnt = 0;
    foreach (slot_ref[i]) slot_ref[i] = 0;
  end

  always @(posedge clk) begin
    lookup_res_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_lookup(in_command, in_pos_x, in_pos_y, in_pos_z);
      if (out_valid && !out_stall) begin
        if (res_q.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          e = res_q.pop_front();
          if (out_vert_idx !== e.vidx) report("vert_idx", out_vert_idx, e.vidx);
          if (out_is_new !== e.fresh) report("is_new", out_is_new, e.fresh);
          if (out_overflow !== e.ovf) report("overflow", out_overflow, e.ovf);
        end
      end
    end
    pending = res_q.size();
  end

  initial pending = 0;
endmodule

// File: sim/vertex_dedup_indexer_tb.sv
// Testbench top: drives vertex lookups and clears, stalls the output, gives the verdict.
`timescale 1ns / 100ps
module vertex_dedup_indexer_tb;
  localparam int IdleLimit = 60000;
  localparam int FillCount = 600;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [31:0] in_pos_x;
  logic [31:0] in_pos_y;
  logic [31:0] in_pos_z;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_vert_idx;
  logic        out_is_new;
  logic        out_overflow;
  int          fail_count;
  int          pending;
  int          n_new;
  int          n_hit;
  int          n_ovf;
  int          n_clr;
  int          send_gap_pct;
  int          recv_stall_pct;
  int          quiet_cycles;
  logic [95:0] vert_pool [48];
  logic [31:0] specials [9];

  vertex_dedup_indexer i_dut (.*);

  vdi_checker i_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    out_stall = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles", IdleLimit);
      $display("Regression FAIL");
      $finish;
    end
  end
  initial quiet_cycles = 0;

  task automatic send_item(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_comp();
    logic [31:0] c;
    c = specials[$urandom_range(8)];
    if (c[30:0] == 0) c[31] = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic random_item();
    int r;
    logic [95:0] p;
    r = $urandom_range(999);
    p = vert_pool[$urandom_range(47)];
    for (int k = 0; k < 3; k++)
      if (p[k*32 +: 31] == 0) p[k*32 + 31] = 1'($urandom_range(1));
    if (r < 8) begin
      send_item(1'b1, $urandom, $urandom, $urandom);
      return;
    end else if (r < 600) begin
    end else if (r < 750) begin
      p = {$urandom, $urandom, $urandom};
    end else if (r < 820) begin
      p[$urandom_range(2)*32 +: 32] = {1'($urandom_range(1)), 8'hFF,
                                       23'($urandom_range(1, 32'h7FFFFF))};
    end else begin
      p[$urandom_range(2)*32 +: 32] = pick_comp();
    end
    send_item(1'b0, p[95:64], p[63:32], p[31:0]);
  endtask

  initial begin
    specials = '{32'h0, 32'h80000000, 32'h3F800000, 32'hBF800000, 32'h7F800000,
                 32'hFF800000, 32'h00000001, 32'h7F7FFFFF, 32'h40490FDB};
    foreach (vert_pool[i]) vert_pool[i] = {pick_comp(), pick_comp(), pick_comp()};
    for (int i = 0; i < 16; i++) vert_pool[i][31:0] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zeros, signed zeros, NaN, infinities, extremes
    send_item(1'b0, 32'h0, 32'h0, 32'h0);
    send_item(1'b0, 32'h80000000, 32'h80000000, 32'h0);
    send_item(1'b0, 32'h0, 32'h80000000, 32'h80000000);
    send_item(1'b0, 32'h7FC00000, 32'h0, 32'h0);
    send_item(1'b0, 32'h7FC00000, 32'h0, 32'h0);
    send_item(1'b0, 32'h0, 32'h0, 32'hFFFFFFFF);
    send_item(1'b0, 32'h7F800000, 32'hFF800000, 32'h7F800000);
    send_item(1'b0, 32'h7F800000, 32'hFF800000, 32'h7F800000);
    send_item(1'b0, 32'h7F7FFFFF, 32'h00000001, 32'h807FFFFF);
    send_item(1'b0, 32'hFFFFFFFE, 32'hFFFFFFFE, 32'hFFFFFFFE);
    send_item(1'b0, 32'h7F800001, 32'h0, 32'h0);
    send_item(1'b0, 32'h7F7FFFFF, 32'h00000001, 32'h807FFFFF);
    send_item(1'b0, 32'h3F800000, 32'h40000000, 32'h40400000);
    send_item(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_item(1'b0, 32'h0, 32'h0, 32'h0);
    send_item(1'b0, 32'h3F800000, 32'h40000000, 32'h40400000);
    send_item(1'b1, 32'h0, 32'h0, 32'h0);
    drain_results();

    // bulk inserts with NaN positions mixed in, then repeats and a clear
    recv_stall_pct = 10;
    send_gap_pct = 10;
    for (int i = 0; i < FillCount; i++)
      send_item(1'b0, 32'h3F800000 + i, 32'h0, (i % 7 == 0) ? 32'h7FC00000 : 32'h80000000);
    send_item(1'b0, 32'h3F800000, 32'h0, 32'h80000000);
    send_item(1'b0, 32'h3F800001, 32'h0, 32'h0);
    send_item(1'b0, 32'h12345678, 32'h0, 32'h0);
    send_item(1'b0, 32'h0, 32'h7FC00001, 32'h0);
    send_item(1'b1, 32'h0, 32'h0, 32'h0);
    drain_results();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 53; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 53; end
        default: begin send_gap_pct = 10; recv_stall_pct = 10; end
      endcase
      repeat (170) random_item();
      if (ph % 3 == 1) drain_results();
    end

    drain_results();
    repeat (200) @(posedge clk);
    $display("covered %0d new vertices, %0d repeat hits, %0d store-full misses, %0d clears",
             n_new, n_hit, n_ovf, n_clr);
    $display("with sender gaps and receiver stalls in four idle mixes");
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
